FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bli: same-cycle check failed");

// next-cycle implication
`define ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bli: next-cycle check failed");

`endif

FILE: design/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg
// Types and constants of the bitrate limit interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bli_pkg;

	localparam int PIX_W           = 26;
	localparam int RATE_W          = 31;
	localparam int PROD_W          = RATE_W + PIX_W;
	localparam int DIV_STEPS       = RATE_W;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
	localparam int DEF_MAX_ENTRIES = 8;

	localparam logic [RATE_W-1:0] INTERP_MIN_RATE = RATE_W'(30000);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [2:0]        slot;
		logic [PIX_W-1:0]  frame_pixels;
		logic [RATE_W-1:0] start_rate_in;
		logic [RATE_W-1:0] min_rate_in;
		logic [RATE_W-1:0] max_rate_in;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [PIX_W-1:0]  out_pixels;
		logic [RATE_W-1:0] start_rate_out;
		logic [RATE_W-1:0] min_rate_out;
		logic [RATE_W-1:0] max_rate_out;
	} result_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixels;
		logic [RATE_W-1:0] start_rate;
		logic [RATE_W-1:0] min_rate;
		logic [RATE_W-1:0] max_rate;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic write;
		logic scan;
		logic decide;
		logic mul_a;
		logic mul_b;
		logic div_init;
		logic div_step;
		logic save;
		logic finish;
		logic sel_max;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic direct;
		logic div_last;
	} status_t;

endpackage

`default_nettype wire

FILE: design/bitrate_limit_interpolator_unit.sv
// ----------------------------------------------------------------------------
// bitrate_limit_interpolator_unit
// Clear and load words hold busy for one cycle after the accepting edge.
// A query scans the table one entry a cycle; a stored result goes straight
// to done, an interpolated one first takes two bit-serial divisions. One
// word at a time; done lasts one cycle.
// Reset clears the valid marks and the sequencer; table data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bitrate_limit_interpolator_unit
	import bli_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	output logic     busy,
	output logic     done,
	output result_t  result
);

	cmd_t    cmd;
	status_t status;

	bli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.status (status),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bli_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: design/bli_ctrl.sv
// ----------------------------------------------------------------------------
// bli_ctrl
// Sequencer: accepts words, steps the datapath through scan, multiply and
// divide passes, and marks the result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bli_ctrl
	import bli_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  status_t    status,
	output logic       busy,
	output logic       done,
	output cmd_t       cmd
);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_CLEAR    = 12'b0000_0000_0010,
		ST_LOAD     = 12'b0000_0000_0100,
		ST_SCAN     = 12'b0000_0000_1000,
		ST_DECIDE   = 12'b0000_0001_0000,
		ST_MUL_A    = 12'b0000_0010_0000,
		ST_MUL_B    = 12'b0000_0100_0000,
		ST_DIV_INIT = 12'b0000_1000_0000,
		ST_DIV      = 12'b0001_0000_0000,
		ST_SAVE     = 12'b0010_0000_0000,
		ST_FINISH   = 12'b0100_0000_0000,
		ST_OUT      = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pass_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (opcode)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_LOAD:  state_d = ST_LOAD;
						OP_QUERY: state_d = ST_SCAN;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR:    state_d = ST_IDLE;
			ST_LOAD:     state_d = ST_IDLE;
			ST_SCAN:     if (status.scan_done) state_d = ST_DECIDE;
			ST_DECIDE:   state_d = status.direct ? ST_OUT : ST_MUL_A;
			ST_MUL_A:    state_d = ST_MUL_B;
			ST_MUL_B:    state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV:      if (status.div_last) state_d = pass_q ? ST_FINISH : ST_SAVE;
			ST_SAVE:     state_d = ST_MUL_A;
			ST_FINISH:   state_d = ST_OUT;
			ST_OUT:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.clear    = (state_q == ST_CLEAR);
		cmd.write    = (state_q == ST_LOAD);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.decide   = (state_q == ST_DECIDE);
		cmd.mul_a    = (state_q == ST_MUL_A);
		cmd.mul_b    = (state_q == ST_MUL_B);
		cmd.div_init = (state_q == ST_DIV_INIT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.save     = (state_q == ST_SAVE);
		cmd.finish   = (state_q == ST_FINISH);
		cmd.sel_max  = pass_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE) pass_q <= 1'b0;
			else if (state_q == ST_SAVE) pass_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: design/bli_dp.sv
// ----------------------------------------------------------------------------
// bli_dp
// Breakpoint table, neighbour scan, shared multiplier and bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bli_dp
	import bli_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     cmd,
	input  in_item_t item,
	output status_t  status,
	output result_t  result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int IW = $clog2(MAX_ENTRIES + 1);

	entry_t                 mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;

	in_item_t               in_q;
	logic [IW-1:0]          idx_q;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic                   rd_en;
	logic                   slot_ok;
	logic                   rd_vld_s1;
	logic                   val_s1;
	entry_t                 rd_s1;

	entry_t                 top_q;
	entry_t                 up_q;
	entry_t                 lo_q;
	logic                   has_top_q;
	logic                   has_up_q;
	logic                   has_lo_q;
	logic                   upd;
	logic                   top_hit;
	logic                   is_up;
	logic                   up_hit;
	logic                   lo_hit;

	logic [PIX_W-1:0]       q;
	logic                   q_zero;
	logic                   found_d;
	result_t                direct_res;

	logic [PIX_W-1:0]       dlo_q;
	logic [PIX_W-1:0]       dhi_q;
	logic [PIX_W-1:0]       span_q;
	logic [RATE_W-1:0]      hi_rate;
	logic [RATE_W-1:0]      lo_rate;
	logic [RATE_W-1:0]      mul_r;
	logic [PIX_W-1:0]       mul_d;
	logic [PROD_W-1:0]      prod;
	logic [PROD_W-1:0]      prod_q;
	logic [PROD_W-1:0]      acc_q;
	logic [PROD_W-1:0]      sum;

	logic [PIX_W-1:0]       rem_q;
	logic [RATE_W-1:0]      dvd_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [PIX_W:0]         trial;
	logic [PIX_W:0]         trial_sub;
	logic                   ge;
	logic [RATE_W-1:0]      start_q;
	result_t                res_q;

	assign q       = in_q.frame_pixels;
	assign rd_addr = idx_q[AW-1:0];
	assign wr_addr = AW'(in_q.slot);
	assign rd_en   = cmd.scan && (idx_q < IW'(MAX_ENTRIES));
	assign slot_ok = (32'(in_q.slot) < MAX_ENTRIES);

	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= item;
	end

	// table
	always_ff @(posedge clk) begin
		if (cmd.write && slot_ok)
			mem[wr_addr] <= '{pixels: in_q.frame_pixels, start_rate: in_q.start_rate_in,
				min_rate: in_q.min_rate_in, max_rate: in_q.max_rate_in};
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1  <= mem[rd_addr];
			val_s1 <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.write && slot_ok) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// neighbour scan
	assign upd     = cmd.scan && rd_vld_s1 && val_s1;
	assign top_hit = !has_top_q || (rd_s1.pixels > top_q.pixels);
	assign is_up   = (rd_s1.pixels >= q);
	assign up_hit  = is_up && (!has_up_q || (rd_s1.pixels < up_q.pixels));
	assign lo_hit  = !is_up && (!has_lo_q || (rd_s1.pixels > lo_q.pixels));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			has_top_q <= 1'b0;
			has_up_q  <= 1'b0;
			has_lo_q  <= 1'b0;
		end else if (cmd.capture) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			has_top_q <= 1'b0;
			has_up_q  <= 1'b0;
			has_lo_q  <= 1'b0;
		end else if (cmd.scan) begin
			rd_vld_s1 <= rd_en;
			if (rd_en) idx_q <= idx_q + 1'b1;
			if (upd && top_hit) has_top_q <= 1'b1;
			if (upd && up_hit) has_up_q <= 1'b1;
			if (upd && lo_hit) has_lo_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && top_hit) top_q <= rd_s1;
		if (upd && up_hit) up_q <= rd_s1;
		if (upd && lo_hit) lo_q <= rd_s1;
	end

	// decision
	assign q_zero  = (q == '0);
	assign found_d = !q_zero && has_top_q;

	always_comb begin
		direct_res = '0;
		if (found_d) begin
			if (!has_up_q)
				direct_res = '{found: 1'b1, out_pixels: top_q.pixels,
					start_rate_out: top_q.start_rate, min_rate_out: top_q.min_rate,
					max_rate_out: top_q.max_rate};
			else
				direct_res = '{found: 1'b1, out_pixels: up_q.pixels,
					start_rate_out: up_q.start_rate, min_rate_out: up_q.min_rate,
					max_rate_out: up_q.max_rate};
		end
	end

	assign status.scan_done = (idx_q == IW'(MAX_ENTRIES)) && !rd_vld_s1;
	assign status.direct    = !found_d || !has_up_q || !has_lo_q || (up_q.pixels == q);
	assign status.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// multiply
	assign hi_rate = cmd.sel_max ? up_q.max_rate : up_q.start_rate;
	assign lo_rate = cmd.sel_max ? lo_q.max_rate : lo_q.start_rate;
	assign mul_r   = cmd.mul_b ? lo_rate : hi_rate;
	assign mul_d   = cmd.mul_b ? dhi_q : dlo_q;
	assign prod    = {{PIX_W{1'b0}}, mul_r} * {{RATE_W{1'b0}}, mul_d};
	assign sum     = acc_q + prod_q;

	// divide
	assign trial     = {rem_q, dvd_q[RATE_W-1]};
	assign trial_sub = trial - {1'b0, span_q};
	assign ge        = (trial >= {1'b0, span_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			dlo_q  <= q - lo_q.pixels;
			dhi_q  <= up_q.pixels - q;
			span_q <= up_q.pixels - lo_q.pixels;
			res_q  <= direct_res;
		end
		if (cmd.mul_a || cmd.mul_b) prod_q <= prod;
		if (cmd.mul_b) acc_q <= prod_q;
		if (cmd.div_init) begin
			rem_q <= sum[PROD_W-1 -: PIX_W];
			dvd_q <= sum[RATE_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
			dvd_q <= {dvd_q[RATE_W-2:0], ge};
		end
		if (cmd.save) start_q <= dvd_q;
		if (cmd.finish) begin
			if (dvd_q < start_q)
				res_q <= '0;
			else
				res_q <= '{found: 1'b1, out_pixels: q, start_rate_out: start_q,
					min_rate_out: INTERP_MIN_RATE, max_rate_out: dvd_q};
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

FILE: design/bli_checker.sv
// ----------------------------------------------------------------------------
// bli_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bli_checker
	import bli_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input in_item_t item,
	input logic     busy,
	input logic     done,
	input result_t  result
);

	`ASSERT_IMP(a_done_while_busy, done, busy)
	`ASSERT_NXT(a_done_single, done, !done)
	`ASSERT_NXT(a_query_holds, start && !busy && item.opcode == OP_QUERY, busy && !done)
	`ASSERT_NXT(a_other_quiet, start && !busy && item.opcode != OP_QUERY, !done)
	`ASSERT_IMP(a_miss_zero, done && !result.found, result.out_pixels == '0 && result.start_rate_out == '0 && result.min_rate_out == '0 && result.max_rate_out == '0)

endmodule

bind bitrate_limit_interpolator_unit bli_checker u_bli_checker (.*);

`default_nettype wire

FILE: dv/bli_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bli_scoreboard
// Watches the word and result channels of the bitrate limit interpolator,
// keeps its own breakpoint table and checks every query result, field by
// field, against the limit it predicts.
// ----------------------------------------------------------------------------

module bli_scoreboard
	import bli_pkg::*;
#(
	parameter int SLOTS = DEF_MAX_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  in_item_t item,
	input  logic     done,
	input  result_t  result,
	output int       fail_count,
	output int       pending
);

	logic    bp_valid [SLOTS];
	entry_t  bp_table [SLOTS];
	result_t expected_limits [$];
	result_t want_limit;
	int      n_fail = 0;

	function automatic logic [RATE_W-1:0] blend_rate(input logic [63:0] lo_rate,
			input logic [63:0] hi_rate, input logic [63:0] lo_pix,
			input logic [63:0] hi_pix, input logic [63:0] q);
		logic [63:0] num;
		num = hi_rate * (q - lo_pix) + lo_rate * (hi_pix - q);
		return RATE_W'(num / (hi_pix - lo_pix));
	endfunction

	function automatic result_t as_limit(input entry_t e);
		result_t lim;
		lim.found          = 1'b1;
		lim.out_pixels     = e.pixels;
		lim.start_rate_out = e.start_rate;
		lim.min_rate_out   = e.min_rate;
		lim.max_rate_out   = e.max_rate;
		return lim;
	endfunction

	function automatic result_t predict_limit(input logic [PIX_W-1:0] q);
		int                up;
		int                lo;
		int                top;
		result_t           lim;
		logic [RATE_W-1:0] s_rate;
		logic [RATE_W-1:0] m_rate;
		up  = -1;
		lo  = -1;
		top = -1;
		lim = '0;
		if (q == '0)
			return lim;
		for (int i = 0; i < SLOTS; i++) begin
			if (!bp_valid[i])
				continue;
			if (top < 0 || bp_table[i].pixels > bp_table[top].pixels)
				top = i;
			if (bp_table[i].pixels >= q) begin
				if (up < 0 || bp_table[i].pixels < bp_table[up].pixels)
					up = i;
			end else if (lo < 0 || bp_table[i].pixels > bp_table[lo].pixels) begin
				lo = i;
			end
		end
		if (top < 0)
			return lim;
		if (up < 0)
			return as_limit(bp_table[top]);
		if (bp_table[up].pixels == q || lo < 0)
			return as_limit(bp_table[up]);
		s_rate = blend_rate(64'(bp_table[lo].start_rate), 64'(bp_table[up].start_rate),
			64'(bp_table[lo].pixels), 64'(bp_table[up].pixels), 64'(q));
		m_rate = blend_rate(64'(bp_table[lo].max_rate), 64'(bp_table[up].max_rate),
			64'(bp_table[lo].pixels), 64'(bp_table[up].pixels), 64'(q));
		if (m_rate < s_rate)
			return lim;
		lim.found          = 1'b1;
		lim.out_pixels     = q;
		lim.start_rate_out = s_rate;
		lim.min_rate_out   = INTERP_MIN_RATE;
		lim.max_rate_out   = m_rate;
		return lim;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				bp_valid[i] = 1'b0;
			expected_limits.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (done) begin
				if (expected_limits.size() == 0) begin
					$error("result word with no query outstanding");
					n_fail++;
				end else begin
					want_limit = expected_limits.pop_front();
					check_field("found", 64'(want_limit.found), 64'(result.found));
					check_field("out_pixels", 64'(want_limit.out_pixels),
						64'(result.out_pixels));
					check_field("start_rate_out", 64'(want_limit.start_rate_out),
						64'(result.start_rate_out));
					check_field("min_rate_out", 64'(want_limit.min_rate_out),
						64'(result.min_rate_out));
					check_field("max_rate_out", 64'(want_limit.max_rate_out),
						64'(result.max_rate_out));
				end
			end
			if (start && !busy) begin
				case (item.opcode)
				OP_CLEAR: begin
					for (int i = 0; i < SLOTS; i++)
						bp_valid[i] = 1'b0;
				end
				OP_LOAD: begin
					if (int'(item.slot) < SLOTS) begin
						bp_valid[item.slot] = 1'b1;
						bp_table[item.slot] = '{pixels: item.frame_pixels,
							start_rate: item.start_rate_in, min_rate: item.min_rate_in,
							max_rate: item.max_rate_in};
					end
				end
				OP_QUERY: expected_limits = {expected_limits,
					predict_limit(item.frame_pixels)};
				default: ;
				endcase
			end
			fail_count <= n_fail;
			pending    <= expected_limits.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, load and query words into the bitrate limit interpolator in
// random bursts: a directed pass over the table corner cases, then random
// load-and-query sequences mixed with noise. The scoreboard predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;
	import bli_pkg::*;

	localparam logic [1:0]        OP_SPARE = 2'd3;
	localparam logic [PIX_W-1:0]  PIX_TOP  = '1;
	localparam logic [RATE_W-1:0] RATE_TOP = '1;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	in_item_t item   = '0;
	logic     busy;
	logic     done;
	result_t  result;
	int       fail_count;
	int       pending;

	int                burst_left = 0;
	int                n_words    = 0;
	logic [PIX_W-1:0]  aim_pix [8];
	logic              aim_set [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bitrate_limit_interpolator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	bli_scoreboard #(
		.SLOTS (DEF_MAX_ENTRIES)
	) u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic [RATE_W-1:0] rand_rate();
		logic [31:0] v;
		v = $urandom();
		return v[RATE_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] rand_pix();
		logic [31:0] v;
		v = $urandom();
		return v[PIX_W-1:0];
	endfunction

	function automatic in_item_t mk_word(input logic [1:0] op, input logic [2:0] sl,
			input logic [PIX_W-1:0] px, input logic [RATE_W-1:0] sr,
			input logic [RATE_W-1:0] mr, input logic [RATE_W-1:0] xr);
		in_item_t w;
		w.opcode        = op;
		w.slot          = sl;
		w.frame_pixels  = px;
		w.start_rate_in = sr;
		w.min_rate_in   = mr;
		w.max_rate_in   = xr;
		return w;
	endfunction

	function automatic in_item_t ask(input logic [PIX_W-1:0] q);
		return mk_word(OP_QUERY, 3'($urandom_range(0, 7)), q, rand_rate(), rand_rate(),
			rand_rate());
	endfunction

	function automatic in_item_t wipe();
		return mk_word(OP_CLEAR, 3'($urandom_range(0, 7)), rand_pix(), rand_rate(),
			rand_rate(), rand_rate());
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixels();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 5)
			return PIX_W'($urandom_range(1, 16) * 4096);
		if (mode < 8)
			return rand_pix();
		if (mode == 8) begin
			case ($urandom_range(0, 3))
			0:       return '0;
			1:       return PIX_W'(1);
			2:       return PIX_TOP;
			default: return PIX_TOP - 1'b1;
			endcase
		end
		return PIX_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [PIX_W-1:0] pick_query();
		int idx;
		int mode;
		idx  = $urandom_range(0, 7);
		mode = $urandom_range(0, 9);
		if (aim_set[idx] && mode < 3)
			return aim_pix[idx];
		if (aim_set[idx] && mode < 5)
			return aim_pix[idx] + PIX_W'($urandom_range(1, 3));
		if (mode == 9)
			return '0;
		return pick_pixels();
	endfunction

	task automatic pick_rates(output logic [RATE_W-1:0] sr, output logic [RATE_W-1:0] mr,
			output logic [RATE_W-1:0] xr);
		logic [RATE_W-1:0] t;
		sr = rand_rate();
		mr = rand_rate();
		xr = rand_rate();
		case ($urandom_range(0, 9))
		0: sr = '0;
		1: xr = RATE_TOP;
		2: begin
			sr = RATE_W'($urandom_range(0, 100000));
			xr = sr + RATE_W'($urandom_range(0, 2000000));
		end
		default: ;
		endcase
		if ($urandom_range(0, 9) < 7 && xr < sr) begin
			t  = xr;
			xr = sr;
			sr = t;
		end
	endtask

	// hold the word until accepted, then either continue the burst or idle
	task automatic issue(input in_item_t w);
		int gap;
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (w.opcode != OP_SPARE)
			n_words++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic run_sequence();
		int                n_loads;
		int                n_asks;
		int                sl;
		logic [RATE_W-1:0] sr;
		logic [RATE_W-1:0] mr;
		logic [RATE_W-1:0] xr;
		if ($urandom_range(0, 9) < 3) begin
			issue(wipe());
			for (int i = 0; i < 8; i++)
				aim_set[i] = 1'b0;
		end
		n_loads = $urandom_range(1, 8);
		n_asks  = $urandom_range(1, 6);
		repeat (n_loads) begin
			sl          = $urandom_range(0, 7);
			aim_pix[sl] = pick_pixels();
			aim_set[sl] = 1'b1;
			pick_rates(sr, mr, xr);
			issue(mk_word(OP_LOAD, 3'(sl), aim_pix[sl], sr, mr, xr));
		end
		repeat (n_asks)
			issue(ask(pick_query()));
	endtask

	initial begin
		#(20_000_000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int base;
		for (int i = 0; i < 8; i++) begin
			aim_pix[i] = '0;
			aim_set[i] = 1'b0;
		end
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ask(PIX_W'(5)));
		issue(ask('0));
		issue(mk_word(OP_LOAD, 3'd0, PIX_W'(1000), RATE_W'(100000), RATE_W'(50000),
			RATE_W'(200000)));
		issue(mk_word(OP_LOAD, 3'd7, PIX_W'(4000), RATE_W'(400000), RATE_W'(70000),
			RATE_W'(800000)));
		issue(mk_word(OP_LOAD, 3'd3, PIX_W'(1000), RATE_W'(111111), RATE_W'(22222),
			RATE_W'(333333)));
		issue(ask(PIX_W'(1000)));
		issue(ask(PIX_W'(500)));
		issue(ask(PIX_W'(5000)));
		issue(ask(PIX_W'(2500)));
		issue(mk_word(OP_LOAD, 3'd5, PIX_TOP, RATE_TOP, RATE_TOP, RATE_TOP));
		issue(ask(PIX_TOP));
		issue(ask(PIX_TOP - 1'b1));
		issue(mk_word(OP_LOAD, 3'd1, PIX_W'(3000), RATE_TOP, RATE_W'(1), '0));
		issue(ask(PIX_W'(3500)));
		issue(mk_word(OP_SPARE, 3'd7, PIX_TOP, RATE_TOP, RATE_TOP, RATE_TOP));
		issue(ask('0));
		issue(wipe());
		issue(ask(PIX_W'(1000)));
		issue(mk_word(OP_LOAD, 3'd2, '0, '0, '0, '0));
		issue(ask(PIX_W'(1)));
		issue(mk_word(OP_LOAD, 3'd4, PIX_W'(1), RATE_W'(7), RATE_W'(3), RATE_W'(9)));
		issue(ask(PIX_W'(1)));
		issue(wipe());
		drain();

		base = n_words;
		while (n_words - base < 1700) begin
			if ($urandom_range(0, 4) == 0)
				issue(mk_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand_pix(),
					rand_rate(), rand_rate(), rand_rate()));
			else
				run_sequence();
			if ($urandom_range(0, 39) == 0)
				drain();
		end

		drain();
		repeat (DEF_MAX_ENTRIES + 80)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/bli_pkg.sv
design/bli_ctrl.sv
design/bli_dp.sv
design/bitrate_limit_interpolator_unit.sv
design/bli_checker.sv
dv/bli_checker.sv
dv/tb_top.sv
